[rtl/core/scpa_pkg.sv]
`timescale 1ns / 1ps

package scpa_pkg;

   localparam int CHUNKS_PER_POOL = 64;
   localparam int MAX_POOLS       = 16;
   localparam int STACK_CAP       = CHUNKS_PER_POOL * MAX_POOLS;
   localparam int NUM_CLASSES     = 3;

   localparam int ADDR_W    = 32;
   localparam int CHUNK_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;

   localparam int DEPTH_W = $clog2(STACK_CAP + 1);
   localparam int FRESH_W = $clog2(CHUNKS_PER_POOL + 1);
   localparam int POOL_W  = $clog2(MAX_POOLS + 1);
   localparam int SLOT_W  = (STACK_CAP > 1) ? $clog2(STACK_CAP) : 1;
   localparam int PROD_W  = SLOT_W + CHUNK_W;

   localparam int RAM_DEPTH = NUM_CLASSES * STACK_CAP;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SMALL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_MID   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_LARGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SMALL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_MID    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LARGE  = 3'd5;

   localparam logic [CHUNK_W-1:0] CHUNK_SMALL_RST = 16'd16;
   localparam logic [CHUNK_W-1:0] CHUNK_MID_RST   = 16'd64;
   localparam logic [CHUNK_W-1:0] CHUNK_LARGE_RST = 16'd256;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CLS_SMALL    = 2'd0,
      CLS_MID      = 2'd1,
      CLS_LARGE    = 2'd2,
      CLS_OVERSIZE = 2'd3
   } size_class_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_OVERSIZE   = 2'd1,
      ST_EXHAUSTED  = 2'd2,
      ST_STACK_FULL = 2'd3
   } status_type;

   typedef struct packed {
      action_type          action;
      logic [ADDR_W-1:0]   num_bytes;
      logic [ADDR_W-1:0]   address;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   chunk_address;
      size_class_type      size_class;
      status_type          status;
   } rsp_word_type;

endpackage

[rtl/core/scpa_ram.sv]
`timescale 1ns / 1ps

module scpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/size_class_pool_allocator.sv]
`timescale 1ns / 1ps

// size-class pool allocator
// req channel: one word per request (allocate or free, byte count, address
// for frees). rsp channel: one word per request, in request order, with the
// chunk address, the size class and a status code.
// csr port: write-only registers for the three chunk sizes and region bases;
// write them only while no request is in flight.
// the free stacks of all three classes share one single-port ram with a
// registered read; depth, fresh and pool counters sit in flops.
// from accept, an oversize request, a free or an exhausted allocate goes
// through S_EXEC and S_DONE; an allocate served from a free stack adds
// S_POP for the ram read, and one cut from the current pool adds S_MUL
// (slot multiply) and S_ADD (base add). one request is in flight at a time,
// so a new word is taken only after the previous one leaves S_DONE.
// the finished word sits in the output register, so a new request is
// accepted while rsp is stalled; a result waits in its last state until the
// output register frees up.
// reset empties all stacks and pools and restores the register defaults.
module size_class_pool_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  scpa_pkg::req_word_type      req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output scpa_pkg::rsp_word_type      rsp_word,
   input  logic                        csr_write_en,
   input  logic [scpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scpa_pkg::CSR_W-1:0]  csr_data
);

   import scpa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP,
      S_MUL,
      S_ADD,
      S_DONE
   } state_type;

   state_type            state_ff;
   action_type           action_ff;
   size_class_type       cls_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    res_addr_ff;
   status_type           res_status_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [PROD_W-1:0]    prod_ff;
   rsp_word_type         rsp_ff;
   logic                 rsp_valid_ff;

   logic [CHUNK_W-1:0]   chunk_small_ff, chunk_mid_ff, chunk_large_ff;
   logic [ADDR_W-1:0]    base_small_ff, base_mid_ff, base_large_ff;

   logic [DEPTH_W-1:0]   depth_ff  [NUM_CLASSES];
   logic [FRESH_W-1:0]   fresh_ff  [NUM_CLASSES];
   logic [POOL_W-1:0]    opened_ff [NUM_CLASSES];

   size_class_type       req_cls;
   logic [1:0]           cls_idx;
   logic [DEPTH_W-1:0]   depth_cur;
   logic [FRESH_W-1:0]   fresh_cur;
   logic [POOL_W-1:0]    opened_cur;
   logic                 open_pool;
   logic [FRESH_W-1:0]   fresh_nx;
   logic [POOL_W-1:0]    opened_nx;
   logic [SLOT_W-1:0]    slot_nx;
   logic [CHUNK_W-1:0]   chunk_sel;
   logic [ADDR_W-1:0]    base_sel;
   logic [SLOT_W-1:0]    stack_idx;
   logic                 ram_we;
   logic [RAM_AW-1:0]    ram_addr;
   logic [ADDR_W-1:0]    ram_rd_data;
   logic                 out_free;

   // class cascade on the incoming word
   always_comb begin
      if (req_word.num_bytes <= {{(ADDR_W-CHUNK_W){1'b0}}, chunk_small_ff}) begin
         req_cls = CLS_SMALL;
      end else if (req_word.num_bytes <= {{(ADDR_W-CHUNK_W){1'b0}}, chunk_mid_ff}) begin
         req_cls = CLS_MID;
      end else if (req_word.num_bytes <= {{(ADDR_W-CHUNK_W){1'b0}}, chunk_large_ff}) begin
         req_cls = CLS_LARGE;
      end else begin
         req_cls = CLS_OVERSIZE;
      end
   end

   always_comb begin
      case (cls_ff)
         CLS_SMALL: begin
            cls_idx   = 2'd0;
            chunk_sel = chunk_small_ff;
            base_sel  = base_small_ff;
         end
         CLS_MID: begin
            cls_idx   = 2'd1;
            chunk_sel = chunk_mid_ff;
            base_sel  = base_mid_ff;
         end
         default: begin
            cls_idx   = 2'd2;
            chunk_sel = chunk_large_ff;
            base_sel  = base_large_ff;
         end
      endcase
   end

   assign depth_cur  = depth_ff[cls_idx];
   assign fresh_cur  = fresh_ff[cls_idx];
   assign opened_cur = opened_ff[cls_idx];

   // fresh-pool path: open the next pool when the current one is used up
   always_comb begin
      open_pool = (fresh_cur == '0) && (opened_cur < POOL_W'(MAX_POOLS));
      opened_nx = open_pool ? opened_cur + POOL_W'(1) : opened_cur;
      fresh_nx  = open_pool ? FRESH_W'(CHUNKS_PER_POOL) : fresh_cur;
      slot_nx   = SLOT_W'(opened_nx - POOL_W'(1)) * SLOT_W'(CHUNKS_PER_POOL)
                + SLOT_W'(fresh_nx - FRESH_W'(1));
   end

   // stack ram access: push writes at depth, pop reads at depth - 1
   always_comb begin
      if (action_ff == ACT_FREE) begin
         stack_idx = depth_cur[SLOT_W-1:0];
      end else begin
         stack_idx = SLOT_W'(depth_cur - DEPTH_W'(1));
      end
      ram_addr = RAM_AW'(cls_idx) * RAM_AW'(STACK_CAP) + RAM_AW'(stack_idx);
      ram_we   = (state_ff == S_EXEC) && (cls_ff != CLS_OVERSIZE)
              && (action_ff == ACT_FREE) && (depth_cur < DEPTH_W'(STACK_CAP));
   end

   scpa_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (RAM_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         chunk_small_ff <= CHUNK_SMALL_RST;
         chunk_mid_ff   <= CHUNK_MID_RST;
         chunk_large_ff <= CHUNK_LARGE_RST;
         base_small_ff  <= '0;
         base_mid_ff    <= '0;
         base_large_ff  <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            depth_ff[i]  <= '0;
            fresh_ff[i]  <= '0;
            opened_ff[i] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_CHUNK_SMALL: chunk_small_ff <= csr_data[CHUNK_W-1:0];
               CSR_CHUNK_MID:   chunk_mid_ff   <= csr_data[CHUNK_W-1:0];
               CSR_CHUNK_LARGE: chunk_large_ff <= csr_data[CHUNK_W-1:0];
               CSR_BASE_SMALL:  base_small_ff  <= csr_data[ADDR_W-1:0];
               CSR_BASE_MID:    base_mid_ff    <= csr_data[ADDR_W-1:0];
               CSR_BASE_LARGE:  base_large_ff  <= csr_data[ADDR_W-1:0];
               default: ;
            endcase
         end

         // in S_DONE the output register reloads whenever it drains
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  action_ff <= req_word.action;
                  addr_ff   <= req_word.address;
                  cls_ff    <= req_cls;
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (cls_ff == CLS_OVERSIZE) begin
                  res_addr_ff   <= '0;
                  res_status_ff <= ST_OVERSIZE;
                  state_ff      <= S_DONE;
               end else if (action_ff == ACT_FREE) begin
                  res_addr_ff <= '0;
                  state_ff    <= S_DONE;
                  if (depth_cur < DEPTH_W'(STACK_CAP)) begin
                     depth_ff[cls_idx] <= depth_cur + DEPTH_W'(1);
                     res_status_ff     <= ST_OK;
                  end else begin
                     res_status_ff <= ST_STACK_FULL;
                  end
               end else if (depth_cur != '0) begin
                  depth_ff[cls_idx] <= depth_cur - DEPTH_W'(1);
                  res_status_ff     <= ST_OK;
                  state_ff          <= S_POP;
               end else if (fresh_nx == '0) begin
                  res_addr_ff   <= '0;
                  res_status_ff <= ST_EXHAUSTED;
                  state_ff      <= S_DONE;
               end else begin
                  opened_ff[cls_idx] <= opened_nx;
                  fresh_ff[cls_idx]  <= fresh_nx - FRESH_W'(1);
                  slot_ff            <= slot_nx;
                  res_status_ff      <= ST_OK;
                  state_ff           <= S_MUL;
               end
            end
            S_POP: begin
               res_addr_ff <= ram_rd_data;
               state_ff    <= S_DONE;
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(slot_ff) * PROD_W'(chunk_sel);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               res_addr_ff <= base_sel + ADDR_W'(prod_ff);
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_ff.chunk_address <= res_addr_ff;
                  rsp_ff.size_class    <= cls_ff;
                  rsp_ff.status        <= res_status_ff;
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
